// ===== src/rcf_pkg.sv =====
// Shared types, constants and helper functions for the one-pole RC filter.
package rcf_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W = 16;                     // audio sample width
  localparam int FRAC_W   = 16;                     // coefficient fraction bits
  localparam int COEFF_W  = FRAC_W + 1;             // Q1.FRAC_W coefficient
  localparam int OP_W     = SAMPLE_W + 2;           // widest multiplier operand
  localparam int PROD_W   = OP_W + 1 + COEFF_W;     // serial product width
  localparam int RND_W    = PROD_W - FRAC_W;        // product after rounding
  localparam int SUM_W    = RND_W + 1;              // lowpass sum before saturation
  localparam int CNT_W    = $clog2(COEFF_W);        // multiplier step counter
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COEFF_W;

  localparam logic [COEFF_W-1:0] COEFF_ONE = COEFF_W'(1) << FRAC_W;

  // Filter modes
  localparam logic [MODE_W-1:0] MODE_LP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BP = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LP_COEFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HP_COEFF = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_in;
  } rcf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
  } rcf_out_t;

  // Request and response of the serial multiplier
  typedef struct packed {
    logic                     start;
    logic signed [OP_W-1:0]   op;
    logic        [COEFF_W-1:0] coef;
  } rcf_mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } rcf_mul_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOW,
    ST_HIGH,
    ST_OUT
  } rcf_state_e;

  // Limit a coefficient to 1.0
  function automatic logic [COEFF_W-1:0] rcf_clamp(input logic [COEFF_W-1:0] c);
    rcf_clamp = (c > COEFF_ONE) ? COEFF_ONE : c;
  endfunction

  // Saturate to the signed sample range
  function automatic logic signed [SAMPLE_W-1:0] rcf_sat(input logic signed [SUM_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[SUM_W-1:SAMPLE_W-1];
    all_zero = ~|v[SUM_W-1:SAMPLE_W-1];
    if (all_one || all_zero) begin
      rcf_sat = v[SAMPLE_W-1:0];
    end else if (v[SUM_W-1]) begin
      rcf_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      rcf_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== src/rcf_serial_mul.sv =====
// Bit-serial shift-add multiplier: signed operand times unsigned coefficient.
module rcf_serial_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcf_pkg::rcf_mul_req_t req_i,
  output rcf_pkg::rcf_mul_rsp_t rsp_o
);

  logic signed [rcf_pkg::OP_W-1:0]    op_q;
  logic signed [rcf_pkg::OP_W:0]      acc_q;
  logic        [rcf_pkg::COEFF_W-1:0] lo_q;
  logic        [rcf_pkg::COEFF_W-1:0] cf_q;
  logic        [rcf_pkg::CNT_W-1:0]   cnt_q;
  logic                               busy_q;
  logic                               done_q;

  logic signed [rcf_pkg::OP_W:0] addend;
  logic signed [rcf_pkg::OP_W:0] sum;
  logic                          last_step;

  // One coefficient bit per cycle, LSB first; shift the partial sum right.
  always_comb begin
    addend    = cf_q[0] ? (rcf_pkg::OP_W+1)'(op_q) : '0;
    sum       = acc_q + addend;
    last_step = (cnt_q == rcf_pkg::CNT_W'(rcf_pkg::COEFF_W - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + rcf_pkg::CNT_W'(1);
      if (last_step) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      cf_q  <= req_i.coef;
      acc_q <= '0;
      lo_q  <= '0;
    end else if (busy_q) begin
      acc_q <= {sum[rcf_pkg::OP_W], sum[rcf_pkg::OP_W:1]};
      lo_q  <= {sum[0], lo_q[rcf_pkg::COEFF_W-1:1]};
      cf_q  <= cf_q >> 1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = {acc_q, lo_q};

endmodule

// ===== src/one_pole_rc_filter.sv =====
// One-pole RC filter top level: lowpass, highpass or bandpass cascade.
// An accepted item runs through two serial multiplications, lowpass then
// highpass, of 17 coefficient bits each, one bit per cycle.
// Items do not overlap: the single shared bit-serial multiplier runs the
// lowpass then the highpass of one item before the next can be accepted.
// The output register lets the next item be accepted while a result waits.
// Reset: mode lowpass, both coefficients 1.0, filter history cleared to zero.
module one_pole_rc_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rcf_pkg::rcf_in_t                    in_data_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rcf_pkg::rcf_out_t                   out_data_o,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [rcf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rcf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // Configuration
  logic [rcf_pkg::MODE_W-1:0]  mode_q;
  logic [rcf_pkg::COEFF_W-1:0] lp_coeff_q;
  logic [rcf_pkg::COEFF_W-1:0] hp_coeff_q;

  // Filter history
  logic signed [rcf_pkg::SAMPLE_W-1:0] prev_in_q;
  logic signed [rcf_pkg::SAMPLE_W-1:0] prev_lo_q;
  logic signed [rcf_pkg::SAMPLE_W-1:0] prev_hi_q;

  // Current item
  logic signed [rcf_pkg::SAMPLE_W-1:0] x_q;
  logic                                last_q;
  logic signed [rcf_pkg::SAMPLE_W-1:0] y_q;
  logic signed [rcf_pkg::SAMPLE_W-1:0] h_q;

  // Output register
  logic              out_valid_q;
  rcf_pkg::rcf_out_t out_data_q;

  rcf_pkg::rcf_state_e state_q, state_d;

  rcf_pkg::rcf_mul_req_t mul_req;
  rcf_pkg::rcf_mul_rsp_t mul_rsp;

  logic                                in_fire;
  logic                                out_free;
  logic                                out_load;
  logic                                high_only;
  logic signed [rcf_pkg::RND_W-1:0]    rnd;
  logic signed [rcf_pkg::SUM_W-1:0]    y_sum;
  logic signed [rcf_pkg::SAMPLE_W-1:0] y_new;
  logic signed [rcf_pkg::SAMPLE_W-1:0] h_new;
  logic signed [rcf_pkg::SAMPLE_W-1:0] h_in;
  logic signed [rcf_pkg::SAMPLE_W-1:0] h_prev;
  logic signed [rcf_pkg::OP_W-1:0]     lp_op;
  logic signed [rcf_pkg::OP_W-1:0]     hp_op;

  rcf_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Datapath around the multiplier
  always_comb begin
    // Round half up: floor((p + half) / 2^FRAC) is the upper bits plus the half bit.
    rnd = mul_rsp.prod[rcf_pkg::PROD_W-1:rcf_pkg::FRAC_W]
        + rcf_pkg::RND_W'(mul_rsp.prod[rcf_pkg::FRAC_W-1]);
    y_sum = rcf_pkg::SUM_W'(prev_lo_q) + rcf_pkg::SUM_W'(rnd);
    y_new = rcf_pkg::rcf_sat(y_sum);
    h_new = rcf_pkg::rcf_sat(rcf_pkg::SUM_W'(rnd));

    // Highpass alone differences the input; otherwise it follows the lowpass.
    high_only = (mode_q == rcf_pkg::MODE_HP);
    h_in      = high_only ? x_q : y_new;
    h_prev    = high_only ? prev_in_q : prev_lo_q;

    lp_op = rcf_pkg::OP_W'(in_data_i.sample_in) - rcf_pkg::OP_W'(prev_lo_q);
    hp_op = rcf_pkg::OP_W'(prev_hi_q) + rcf_pkg::OP_W'(h_in) - rcf_pkg::OP_W'(h_prev);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = rcf_pkg::ST_LOW;
        end
      end
      rcf_pkg::ST_LOW: begin
        if (mul_rsp.done) begin
          state_d = rcf_pkg::ST_HIGH;
        end
      end
      rcf_pkg::ST_HIGH: begin
        if (mul_rsp.done) begin
          state_d = rcf_pkg::ST_OUT;
        end
      end
      rcf_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = rcf_pkg::ST_IDLE;
        end
      end
      default: state_d = rcf_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    out_free     = !out_valid_q || out_ready_i;
    in_ready_o   = 1'b0;
    out_load     = 1'b0;
    mul_req.op   = hp_op;
    mul_req.coef = hp_coeff_q;
    mul_req.start = 1'b0;
    unique case (state_q)
      rcf_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        mul_req.op    = lp_op;
        mul_req.coef  = lp_coeff_q;
        mul_req.start = in_valid_i;
      end
      rcf_pkg::ST_LOW: begin
        mul_req.start = mul_rsp.done;
      end
      rcf_pkg::ST_HIGH: begin
      end
      rcf_pkg::ST_OUT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
    in_fire = in_valid_i && in_ready_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers; coefficients above 1.0 are stored as 1.0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= rcf_pkg::MODE_LP;
      lp_coeff_q <= rcf_pkg::COEFF_ONE;
      hp_coeff_q <= rcf_pkg::COEFF_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rcf_pkg::CFG_MODE:     mode_q     <= cfg_data_i[rcf_pkg::MODE_W-1:0];
        rcf_pkg::CFG_LP_COEFF: lp_coeff_q <= rcf_pkg::rcf_clamp(cfg_data_i);
        rcf_pkg::CFG_HP_COEFF: hp_coeff_q <= rcf_pkg::rcf_clamp(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // Hold the item and the two stage results
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q    <= in_data_i.sample_in;
      last_q <= in_data_i.last_in;
    end
    if (state_q == rcf_pkg::ST_LOW && mul_rsp.done) begin
      y_q <= y_new;
    end
    if (state_q == rcf_pkg::ST_HIGH && mul_rsp.done) begin
      h_q <= h_new;
    end
  end

  // Advance the history when the result is loaded into the output register; a last item clears it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_in_q <= '0;
      prev_lo_q <= '0;
      prev_hi_q <= '0;
    end else if (out_load) begin
      prev_in_q <= last_q ? '0 : x_q;
      prev_lo_q <= last_q ? '0 : y_q;
      prev_hi_q <= last_q ? '0 : h_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.sample_out <= (mode_q == rcf_pkg::MODE_LP) ? y_q : h_q;
      out_data_q.last_out   <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A multiplier result only appears while a filter stage waits for it.
  a_done_in_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == rcf_pkg::ST_LOW || state_q == rcf_pkg::ST_HIGH))
    else $error("multiplier done outside a filter stage");

  // An accepted item starts the lowpass multiplication.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> mul_req.start)
    else $error("accepted item did not start the multiplier");

  // A finished result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcf_pkg::ST_OUT && out_valid_o && !out_ready_i)
      |=> (state_q == rcf_pkg::ST_OUT && out_valid_o))
    else $error("output overwritten while stalled");

  // A last item leaves the history cleared.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_q) |=> (prev_in_q == '0 && prev_lo_q == '0 && prev_hi_q == '0))
    else $error("history not cleared after last item");

endmodule
